@@ rtl/core/metropolis_path_site_update_defines.svh @@
// Assertion macros for the site update block.
// Each use expects i_clk and i_rst_n in the enclosing module.
`ifndef METROPOLIS_PATH_SITE_UPDATE_DEFINES_SVH
`define METROPOLIS_PATH_SITE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define MPSU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mpsu assertion failed");
`define MPSU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mpsu assertion failed");
`else
`define MPSU_ASSERT(lbl, prop)
`define MPSU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/core/mpsu_pkg.sv @@
package mpsu_pkg;

    localparam int MAX_SITES      = 512;
    localparam int ADDR_W         = $clog2(MAX_SITES);
    localparam int LEN_W          = ADDR_W + 1;
    localparam int EXP_TABLE_BITS = 8;
    localparam int TABLE_SIZE     = 1 << EXP_TABLE_BITS;

    localparam logic [31:0] SEED_RESET = 32'd123456789;
    localparam logic [31:0] RNG_Y_INIT = 32'd362436069;
    localparam logic [31:0] RNG_Z_INIT = 32'd521288629;
    localparam logic [31:0] RNG_W_INIT = 32'd88675123;
    localparam logic [31:0] RNG_MASK   = 32'h7FFF_FFFF;
    localparam int          RNG_SHL    = 11;
    localparam int          RNG_SHR    = 19;
    localparam int          RNG_SHT    = 8;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // configuration register indexes
    localparam logic [2:0] CFG_STEP_SIZE = 3'd0;
    localparam logic [2:0] CFG_SPACING   = 3'd1;
    localparam logic [2:0] CFG_INV_SPACE = 3'd2;
    localparam logic [2:0] CFG_PATH_LEN  = 3'd3;
    localparam logic [2:0] CFG_SEED      = 3'd4;

    // operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    typedef logic [TABLE_SIZE-1:0][31:0] t_exp_tab;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        rem  = v;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^-(k/TABLE_SIZE) in Q1.31, built at elaboration
    function automatic t_exp_tab exp_table_build();
        t_exp_tab    tab;
        logic [63:0] q;
        logic [63:0] t;
        q = 64'd1 << 30;
        for (int i = 0; i < EXP_TABLE_BITS; i++) q = isqrt64(q << 31);
        t = 64'd1 << 31;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            tab[k] = t[31:0];
            t = (t * q + (64'd1 << 30)) >> 31;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TABLE = exp_table_build();

endpackage

@@ rtl/core/metropolis_path_site_update.sv @@
// Path: a no-op goes straight to FIN, a write through WR, a read through RX and RD, and
// an update through RX, RL, RR and M1 to M11 (RX, RD if its site is past the path length).
// Flow: one item at a time; FIN loads the output register, the input reopens once the
// result sits there, and FIN waits while the sink stalls. The chain of memory reads (site,
// left, right) and registered multiplies sets the update time. Reset: synchronous, active
// low; a clearing pass then writes zero to all 512 path entries, one per cycle, no input taken.
`include "metropolis_path_site_update_defines.svh"

module metropolis_path_site_update
    import mpsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [8:0] site, [40:9] write_value, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [31:0] position, [63:32] increment
    output logic        o_m_tuser    // [0] accepted
);

    // sequencer codes
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_WR   = 5'd1;
    localparam logic [4:0] ST_RX   = 5'd2;
    localparam logic [4:0] ST_RD   = 5'd3;
    localparam logic [4:0] ST_RL   = 5'd4;
    localparam logic [4:0] ST_RR   = 5'd5;
    localparam logic [4:0] ST_M1   = 5'd6;
    localparam logic [4:0] ST_M2   = 5'd7;
    localparam logic [4:0] ST_M3   = 5'd8;
    localparam logic [4:0] ST_M4   = 5'd9;
    localparam logic [4:0] ST_M5   = 5'd10;
    localparam logic [4:0] ST_M6   = 5'd11;
    localparam logic [4:0] ST_M7   = 5'd12;
    localparam logic [4:0] ST_M8   = 5'd13;
    localparam logic [4:0] ST_M9   = 5'd14;
    localparam logic [4:0] ST_M10  = 5'd15;
    localparam logic [4:0] ST_M11  = 5'd16;
    localparam logic [4:0] ST_FIN  = 5'd17;

    localparam logic signed [46:0] S_LIMIT = 47'sd1 << 40;

    // configuration registers
    logic [19:0] r_step;
    logic [19:0] r_spacing;
    logic [25:0] r_inv;
    logic [9:0]  r_len;

    // control
    logic [4:0]        r_state, n_state;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_cnt;
    logic              r_ov;

    // item payload and working values
    logic [1:0]         r_op;
    logic [8:0]         r_site;
    logic [31:0]        r_wval;
    logic [ADDR_W-1:0]  r_li, r_ri;
    logic signed [31:0] r_x, r_l;
    logic signed [33:0] r_d;
    logic signed [21:0] r_inc;
    logic signed [33:0] r_t1;
    logic signed [36:0] r_t2;
    logic signed [44:0] r_t3;
    logic signed [41:0] r_s;
    logic signed [42:0] r_ph;
    logic signed [43:0] r_pl;
    logic signed [47:0] r_e;
    logic               r_e_le0, r_e_big;
    logic [5:0]         r_ip;
    logic [EXP_TABLE_BITS-1:0] r_idx;
    logic signed [31:0] r_pos;
    logic               r_acc;
    logic signed [31:0] r_res_inc;
    logic [63:0]        r_m_tdata;
    logic               r_m_tuser;

    // memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;

    logic        rng_step;
    logic [30:0] rng_word;

    logic in_xfer;
    logic slot_free;

    assign o_s_tready = (r_state == ST_IDLE) && !r_clr_busy;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_ov || i_m_tready;

    // effective length, clamped to [1, MAX_SITES]
    logic [LEN_W:0] len_eff;
    logic           site_in_len;
    always_comb begin
        len_eff = (LEN_W + 1)'(r_len);
        if (len_eff == '0) len_eff = (LEN_W + 1)'(1);
        if (len_eff > (LEN_W + 1)'(MAX_SITES)) len_eff = (LEN_W + 1)'(MAX_SITES);
        site_in_len   = (LEN_W + 1)'(r_site) < len_eff;
    end

    mpsu_ram #(
        .WIDTH(32),
        .DEPTH(MAX_SITES)
    ) u_path (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    mpsu_rng u_rng (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (i_cfg_we && (i_cfg_index == CFG_SEED)),
        .i_seed (i_cfg_data),
        .i_step (rng_step),
        .o_word (rng_word)
    );

    // draw the proposal word at M1 and the acceptance word at M2
    assign rng_step = (r_state == ST_M1) || (r_state == ST_M2);

    // saturated accepted position
    logic signed [32:0] sum_raw;
    logic signed [31:0] sum_sat;
    always_comb begin
        sum_raw = 33'(r_x) + 33'(r_inc);
        if (sum_raw > 33'sd2147483647) sum_sat = 32'sh7FFF_FFFF;
        else if (sum_raw < -33'sd2147483648) sum_sat = 32'sh8000_0000;
        else sum_sat = sum_raw[31:0];
    end

    // acceptance test against the table value
    logic [31:0] p_val;
    logic        acc_now;
    always_comb begin
        p_val   = (r_ip >= 6'd32) ? 32'd0 : (EXP_TABLE[r_idx] >> r_ip[4:0]);
        acc_now = r_e_le0 || (!r_e_big && ({1'b0, rng_word} < p_val));
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = ADDR_W'(r_site);
        ram_wdata = r_wval;
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_addr  = r_clr_cnt;
            ram_wdata = '0;
        end else begin
            case (r_state)
                ST_WR:  ram_we = 1'b1;
                ST_RL:  ram_addr = r_li;
                ST_RR:  ram_addr = r_ri;
                ST_M11: begin
                    ram_we    = acc_now;
                    ram_wdata = sum_sat;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (i_s_tuser == OP_NOP || !((LEN_W + 1)'(i_s_tdata[8:0])
                            < (LEN_W + 1)'(MAX_SITES))) n_state = ST_FIN;
                    else if (i_s_tuser == OP_WRITE) n_state = ST_WR;
                    else n_state = ST_RX;
                end
            end
            ST_WR:  n_state = ST_FIN;
            ST_RX:  n_state = (r_op == OP_UPDATE && site_in_len) ? ST_RL : ST_RD;
            ST_RD:  n_state = ST_FIN;
            ST_RL:  n_state = ST_RR;
            ST_RR:  n_state = ST_M1;
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_M3;
            ST_M3:  n_state = ST_M4;
            ST_M4:  n_state = ST_M5;
            ST_M5:  n_state = ST_M6;
            ST_M6:  n_state = ST_M7;
            ST_M7:  n_state = ST_M8;
            ST_M8:  n_state = ST_M9;
            ST_M9:  n_state = ST_M10;
            ST_M10: n_state = ST_M11;
            ST_M11: n_state = ST_FIN;
            ST_FIN: if (slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_ov       <= 1'b0;
            r_step     <= 20'd13107;
            r_spacing  <= 20'd6554;
            r_inv      <= 26'd655360;
            r_len      <= 10'd500;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == ADDR_W'(MAX_SITES - 1)) r_clr_busy <= 1'b0;
            end
            // hold the result until the sink takes it
            if (r_state == ST_FIN && slot_free) r_ov <= 1'b1;
            else if (i_m_tready) r_ov <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STEP_SIZE: r_step    <= i_cfg_data[19:0];
                    CFG_SPACING:   r_spacing <= i_cfg_data[19:0];
                    CFG_INV_SPACE: r_inv     <= i_cfg_data[25:0];
                    CFG_PATH_LEN:  r_len     <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath, at most one registered multiply per step
    logic signed [17:0] u_val;
    logic signed [38:0] p_inc;
    logic signed [49:0] p_t1;
    logic signed [52:0] p_t2;
    logic signed [60:0] p_t3;
    logic signed [46:0] s_raw;
    logic signed [63:0] e_full;
    logic [37:0]        y_full;
    logic [31:0]        u_sh;
    always_comb begin
        u_sh   = {rng_word[29:0], 2'b00};
        u_val  = $signed({1'b0, u_sh[31:15]}) - 18'sd65536;
        p_inc  = $signed({1'b0, r_step}) * u_val;
        p_t1   = $signed({1'b0, 27'(r_spacing >> 1) + 27'(r_inv)}) * r_inc;
        p_t2   = $signed({1'b0, r_spacing}) * r_x;
        p_t3   = $signed({1'b0, r_inv}) * r_d;
        s_raw  = 47'(r_t1) + 47'(r_t2) + 47'(r_t3);
        e_full = (64'(r_ph) <<< 21) + 64'(r_pl);
        y_full = 38'(r_e[20:0]) * 38'(LOG2E_Q16);
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op   <= i_s_tuser;
            r_site <= i_s_tdata[8:0];
            r_wval <= i_s_tdata[40:9];
            r_pos     <= '0;
            r_acc     <= 1'b0;
            r_res_inc <= '0;
        end
        case (r_state)
            ST_WR: r_pos <= r_wval;
            ST_RX: begin
                r_li <= (r_site == '0) ? ADDR_W'(len_eff - 1'b1) : ADDR_W'(r_site) - 1'b1;
                r_ri <= ((LEN_W + 1)'(r_site) == len_eff - 1'b1) ? '0
                        : ADDR_W'(r_site) + 1'b1;
            end
            ST_RD: r_pos <= ram_rdata;
            ST_RL: r_x <= ram_rdata;
            ST_RR: r_l <= ram_rdata;
            ST_M1: r_d <= (34'(r_x) <<< 1) - 34'(r_l) - 34'($signed(ram_rdata));
            ST_M2: r_inc <= p_inc[37:16];
            ST_M3: r_t1 <= p_t1[49:16];
            ST_M4: r_t2 <= p_t2[52:16];
            ST_M5: r_t3 <= p_t3[60:16];
            ST_M6: begin
                if (s_raw > S_LIMIT) r_s <= 42'(S_LIMIT);
                else if (s_raw < -S_LIMIT) r_s <= 42'(-S_LIMIT);
                else r_s <= s_raw[41:0];
            end
            ST_M7: r_ph <= r_inc * $signed(r_s[41:21]);
            ST_M8: r_pl <= r_inc * $signed({1'b0, r_s[20:0]});
            ST_M9: r_e <= e_full[63:16];
            ST_M10: begin
                r_e_le0 <= r_e[47] || (r_e == '0);
                r_e_big <= !r_e[47] && (r_e[47:21] != '0);
                r_ip    <= y_full[37:32];
                r_idx   <= y_full[31 -: EXP_TABLE_BITS];
            end
            ST_M11: begin
                r_acc     <= acc_now;
                r_res_inc <= 32'(r_inc);
                r_pos     <= acc_now ? sum_sat : r_x;
            end
            default: ;
        endcase
        if (r_state == ST_FIN && slot_free) begin
            r_m_tdata <= {r_res_inc, r_pos};
            r_m_tuser <= r_acc;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    `MPSU_ASSERT(a_ready_idle, o_s_tready |-> (r_state == ST_IDLE && !r_clr_busy))
    `MPSU_ASSERT(a_xfer_leaves_idle, in_xfer |=> (r_state != ST_IDLE))
    `MPSU_ASSERT(a_mem_write_src, ram_we |-> (r_clr_busy || r_state == ST_WR || r_state == ST_M11))
    `MPSU_ASSERT(a_rng_update_only, rng_step |-> (r_op == OP_UPDATE && !r_clr_busy))

endmodule

@@ rtl/core/mpsu_ram.sv @@
module mpsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mpsu_rng.sv @@
module mpsu_rng
    import mpsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [31:0] i_seed,
    input  logic        i_step,
    output logic [30:0] o_word
);

    logic [31:0] r_x, r_y, r_z, r_w;
    logic [31:0] t;
    logic [31:0] n_w;

    always_comb begin
        t   = r_x ^ (r_x << RNG_SHL);
        n_w = (r_w ^ (r_w >> RNG_SHR) ^ (t ^ (t >> RNG_SHT))) & RNG_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= SEED_RESET;
            r_y <= RNG_Y_INIT;
            r_z <= RNG_Z_INIT;
            r_w <= RNG_W_INIT;
        end else if (i_load) begin
            r_x <= i_seed;
            r_y <= RNG_Y_INIT;
            r_z <= RNG_Z_INIT;
            r_w <= RNG_W_INIT;
        end else if (i_step) begin
            r_x <= r_y;
            r_y <= r_z;
            r_z <= r_w;
            r_w <= n_w;
        end
    end

    assign o_word = r_w[30:0];

endmodule
